/* rtl/ssmpm_pkg.sv */
package ssmpm_pkg;

    localparam int PAT_LEN        = 8;
    localparam int SEED_LENGTH    = 16;
    localparam int NUM_SEEDS      = 4;
    localparam int NUM_ENTRIES    = 1 << (PAT_LEN - 1);
    localparam int SIG_BITS       = SEED_LENGTH * NUM_SEEDS;
    localparam int IDX_W          = 7;
    localparam int CNT_W          = 8;
    localparam int DIST_W         = 14;
    localparam int PART_W         = 11;
    localparam int GROUPS         = 8;
    localparam int GROUP_SIZE     = SIG_BITS / GROUPS;
    localparam int MASK_W         = 16;
    localparam int CFG_IDX_W      = 2;

    typedef logic [SIG_BITS-1:0]          sig_t;
    typedef logic [SIG_BITS-1:0][CNT_W-1:0] ones_t;
    typedef logic [3:0][MASK_W-1:0]       masks_t;

    // scan status handed to the top level
    typedef struct packed {
        logic              done;
        logic [IDX_W-1:0]  index;
        logic [DIST_W-1:0] distance;
    } scan_res_t;

    // predicted miss signature of the pattern at a table index
    function automatic sig_t predict(input logic [IDX_W-1:0] idx, input masks_t masks);
        sig_t                      sig;
        logic [PAT_LEN-1:0]        pat;
        int                        k;
        sig = '0;
        pat = {idx, 1'b1};
        for (int s = 0; s < SEED_LENGTH; s++) begin
            for (int j = 0; j < NUM_SEEDS; j++) begin
                for (int p = 0; p < PAT_LEN; p++) begin
                    k = SEED_LENGTH - 1 - s + p;
                    if (p <= s && pat[p] && masks[j][k])
                        sig[s*NUM_SEEDS + j] = 1'b1;
                end
            end
        end
        return sig;
    endfunction

endpackage

/* rtl/ssmpm_sig_table.sv */
module ssmpm_sig_table (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ssmpm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ssmpm_pkg::MASK_W-1:0]    cfg_data,
    input  logic [ssmpm_pkg::IDX_W-1:0]     rd_addr,
    output ssmpm_pkg::sig_t                 rd_data,
    output ssmpm_pkg::ones_t                ones,
    output logic                            ready
);
    import ssmpm_pkg::*;

    sig_t               mem [NUM_ENTRIES];
    sig_t               rd_data_reg;
    masks_t             masks_reg;
    ones_t              ones_reg;
    logic               build_reg;
    logic [IDX_W:0]     bidx_reg;
    sig_t               build_sig;

    assign build_sig = predict(bidx_reg[IDX_W-1:0], masks_reg);

    // mask registers, builder sweep and per-bit set counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            masks_reg <= '1;
            build_reg <= 1'b1;
            bidx_reg  <= '0;
            ones_reg  <= '0;
        end
        else if (cfg_we)
        begin
            masks_reg[cfg_index] <= cfg_data;
            build_reg <= 1'b1;
            bidx_reg  <= '0;
            ones_reg  <= '0;
        end
        else if (build_reg)
        begin
            for (int b = 0; b < SIG_BITS; b++)
                ones_reg[b] <= ones_reg[b] + CNT_W'(build_sig[b]);
            bidx_reg <= bidx_reg + 1'b1;
            if (bidx_reg == (IDX_W+1)'(NUM_ENTRIES - 1))
                build_reg <= 1'b0;
        end
    end

    // signature memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (build_reg && !cfg_we)
            mem[bidx_reg[IDX_W-1:0]] <= build_sig;
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign ones    = ones_reg;
    assign ready   = !build_reg;

endmodule

/* rtl/ssmpm_scan.sv */
module ssmpm_scan (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  ssmpm_pkg::sig_t             obs,
    output logic [ssmpm_pkg::IDX_W-1:0] rd_addr,
    input  ssmpm_pkg::sig_t             rd_data,
    input  ssmpm_pkg::ones_t            ones,
    output ssmpm_pkg::scan_res_t        res
);
    import ssmpm_pkg::*;

    logic                          active_reg;
    logic [IDX_W:0]                addr_reg;
    sig_t                          obs_reg;
    logic                          rv_reg;
    logic [IDX_W-1:0]              ridx_reg;
    logic                          pv_reg;
    logic [IDX_W-1:0]              pidx_reg;
    logic [GROUPS-1:0][PART_W-1:0] part_reg;
    logic [GROUPS-1:0][PART_W-1:0] part_next;
    logic                          tv_reg;
    logic [IDX_W-1:0]              tidx_reg;
    logic [DIST_W-1:0]             tot_reg;
    logic [DIST_W-1:0]             tot_next;
    logic                          have_reg;
    logic [IDX_W-1:0]              best_idx_reg;
    logic [DIST_W-1:0]             best_dist_reg;
    logic                          done_reg;
    sig_t                          diff;
    logic [SIG_BITS-1:0][CNT_W-1:0] w;

    assign rd_addr = addr_reg[IDX_W-1:0];
    assign diff    = obs_reg ^ rd_data;

    // per-bit weights and group sums of differing bits
    always_comb
    begin
        for (int b = 0; b < SIG_BITS; b++)
            w[b] = obs_reg[b] ? ones[b] : CNT_W'(NUM_ENTRIES) - ones[b];
        for (int g = 0; g < GROUPS; g++)
        begin
            part_next[g] = '0;
            for (int e = 0; e < GROUP_SIZE; e++)
                if (diff[g*GROUP_SIZE + e])
                    part_next[g] = part_next[g] + PART_W'(w[g*GROUP_SIZE + e]);
        end
        tot_next = '0;
        for (int g = 0; g < GROUPS; g++)
            tot_next = tot_next + DIST_W'(part_reg[g]);
    end

    // address issue and pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            addr_reg   <= '0;
            rv_reg     <= 1'b0;
            pv_reg     <= 1'b0;
            tv_reg     <= 1'b0;
            have_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            rv_reg   <= active_reg;
            pv_reg   <= rv_reg;
            tv_reg   <= pv_reg;
            done_reg <= tv_reg && (tidx_reg == IDX_W'(NUM_ENTRIES - 1));
            if (start)
            begin
                active_reg <= 1'b1;
                addr_reg   <= '0;
            end
            else if (active_reg)
            begin
                addr_reg <= addr_reg + 1'b1;
                if (addr_reg == (IDX_W+1)'(NUM_ENTRIES - 1))
                    active_reg <= 1'b0;
            end
            if (start)
                have_reg <= 1'b0;
            else if (tv_reg)
                have_reg <= 1'b1;
        end
    end

    // data path and running minimum, later entry wins ties
    always_ff @(posedge clk)
    begin
        if (start)
            obs_reg <= obs;
        ridx_reg <= addr_reg[IDX_W-1:0];
        pidx_reg <= ridx_reg;
        part_reg <= part_next;
        tidx_reg <= pidx_reg;
        tot_reg  <= tot_next;
        if (tv_reg && (!have_reg || tot_reg <= best_dist_reg))
        begin
            best_idx_reg  <= tidx_reg;
            best_dist_reg <= tot_reg;
        end
    end

    assign res.done     = done_reg;
    assign res.index    = best_idx_reg;
    assign res.distance = best_dist_reg;

endmodule

/* rtl/spaced_seed_miss_pattern_matcher.sv */
// Spaced-seed miss pattern matcher.
// Input stream s_axis carries one 64-bit observed miss signature per transfer.
// Output stream m_axis returns the nearest mismatch pattern, its table index
// and its weighted distance, one result per input transfer.
// Configuration: cfg_we with cfg_index 0..3 writes the care masks of seeds
// 0..3; each write restarts the table build. Reset sets all masks to ones.
// Table build: after reset and after every mask write the 128 predicted
// signatures are written into the signature memory, one entry a cycle, and
// s_axis_tready stays low until the build is done.
// Scan: one memory entry is read per cycle through a three-stage distance
// pipeline, so one item occupies the block for 128 reads plus pipeline drain.
// One item at a time: s_axis_tready stays low until its result is loaded.
// A result waits in the output register while m_axis_tready is low; the
// next input can be taken meanwhile, and its scan holds its result until the
// output register frees.
module spaced_seed_miss_pattern_matcher (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [63:0]                     s_axis_tdata,  // observed_signature
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [31:0]                     m_axis_tdata,  // best_pattern, best_index, best_distance
    input  logic                            cfg_we,
    input  logic [ssmpm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ssmpm_pkg::MASK_W-1:0]    cfg_data
);
    import ssmpm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic               out_valid_reg;
    logic [IDX_W-1:0]   out_idx_reg;
    logic [DIST_W-1:0]  out_dist_reg;
    logic               table_ready;
    logic [IDX_W-1:0]   rd_addr;
    sig_t               rd_data;
    ones_t              ones;
    scan_res_t          res;
    logic               start;
    logic               load;

    ssmpm_sig_table u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .ones      (ones),
        .ready     (table_ready)
    );

    ssmpm_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .obs     (s_axis_tdata),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .ones    (ones),
        .res     (res)
    );

    assign s_axis_tready = (state_reg == ST_IDLE) && table_ready;
    assign start         = s_axis_tvalid && s_axis_tready;

    // load the output register when a result is ready and the slot is free
    always_comb
    begin
        state_next = state_reg;
        load       = 1'b0;
        case (state_reg)
            ST_IDLE:
                if (start)
                    state_next = ST_SCAN;
            ST_SCAN:
                if (res.done)
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        load       = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                        state_next = ST_HOLD;
                end
            ST_HOLD:
                if (!out_valid_reg || m_axis_tready)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_idx_reg  <= res.index;
            out_dist_reg <= res.distance;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_dist_reg, out_idx_reg, out_idx_reg, 1'b1};

endmodule

/* rtl/ssmpm_checker.sv */
module ssmpm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // a held result keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one item at a time: busy right after an input transfer
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken during a scan");

    // pattern always has position 0 mismatched and matches its index
    a_pat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[0] && (m_axis_tdata[7:1] == m_axis_tdata[14:8]))
        else $error("pattern and index disagree");

    // distance bounded by 64 bits of weight 128
    a_dist: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[28:15] <= 14'd8192) && (m_axis_tdata[31:29] == 3'b000))
        else $error("distance out of range");

endmodule

bind spaced_seed_miss_pattern_matcher ssmpm_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* bench/tb_spaced_seed_miss_pattern_matcher.sv */
module tb_spaced_seed_miss_pattern_matcher;
    import ssmpm_pkg::*;

    // result fields, highest bit first
    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [IDX_W-1:0]  index;
        logic [7:0]        pattern;
    } match_t;

    // directed stimulus row: signature and, where obvious, expected distance
    typedef struct {
        logic [63:0] sig;
        logic        has_dist;
        logic [DIST_W-1:0] exp_dist;
    } query_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [63:0]           s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [31:0]           m_axis_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [MASK_W-1:0]     cfg_data;

    // model state
    logic [15:0]  seed_care [4];
    logic [63:0]  pattern_sig [NUM_ENTRIES];
    int unsigned  bit_ones [64];

    match_t       pending_matches [$];
    int           error_count;
    int           result_count;
    int           item_count;
    int           send_idle_pct;
    int           recv_idle_pct;
    query_row_t   directed_rows [$];

    spaced_seed_miss_pattern_matcher DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // observed_signature
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // best_pattern, best_index, best_distance
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // rebuild the signature table from the care masks
    task automatic rebuild_table();
        logic [7:0] pat;
        logic       hit;
        for (int b = 0; b < 64; b++)
            bit_ones[b] = 0;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            pat = {i[6:0], 1'b1};
            pattern_sig[i] = '0;
            for (int s = 0; s < SEED_LENGTH; s++)
            begin
                for (int j = 0; j < NUM_SEEDS; j++)
                begin
                    hit = 1'b0;
                    for (int p = 0; p < PAT_LEN && p <= s; p++)
                        if (pat[p] && seed_care[j][SEED_LENGTH - 1 - s + p])
                            hit = 1'b1;
                    pattern_sig[i][s*NUM_SEEDS + j] = hit;
                end
            end
            for (int b = 0; b < 64; b++)
                if (pattern_sig[i][b])
                    bit_ones[b]++;
        end
    endtask

    // nearest pattern for an observed signature, later entry wins ties
    function automatic match_t nearest_pattern(logic [63:0] obs);
        match_t       m;
        int unsigned  cur_dist;
        int unsigned  best_dist;
        int unsigned  best;
        logic [63:0]  diff;
        best = 0;
        best_dist = 0;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            diff = obs ^ pattern_sig[i];
            cur_dist = 0;
            for (int b = 0; b < 64; b++)
                if (diff[b])
                    cur_dist += obs[b] ? bit_ones[b] : NUM_ENTRIES - bit_ones[b];
            if (i == 0 || cur_dist <= best_dist)
            begin
                best = i;
                best_dist = cur_dist;
            end
        end
        m.pattern  = {best[6:0], 1'b1};
        m.index    = best[6:0];
        m.distance = (best_dist > 16383) ? 14'd16383 : best_dist[DIST_W-1:0];
        return m;
    endfunction

    // append one directed row
    function automatic void add_row(logic [63:0] sig, logic has_dist,
                                    logic [DIST_W-1:0] exp_dist);
        query_row_t row;
        row.sig      = sig;
        row.has_dist = has_dist;
        row.exp_dist = exp_dist;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // one input transfer, with random idling before it
    task automatic send_signature(logic [63:0] sig);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sig;
        pending_matches.insert(pending_matches.size(), nearest_pattern(sig));
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        item_count++;
    endtask

    // wait for every expected result, then the scan tail
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (150)
            @(posedge clk);
    endtask

    // mask write while idle
    task automatic write_mask(int idx, logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx[CFG_IDX_W-1:0];
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        seed_care[idx] = value;
        rebuild_table();
        @(posedge clk);
    endtask

    // random signature with sparse, dense, near-table or uniform content
    function automatic logic [63:0] random_signature();
        logic [63:0] v;
        logic [63:0] m;
        v = {$urandom, $urandom};
        m = {$urandom, $urandom};
        case ($urandom_range(3))
            0: return v & m;
            1: return v | m;
            2: return pattern_sig[$urandom_range(NUM_ENTRIES - 1)] ^ (v & m & {$urandom, $urandom});
            default: return v;
        endcase
    endfunction

    // receiver: random stall and result check
    always @(posedge clk)
    begin
        match_t got;
        match_t want;
        if (rst_n)
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[28:0];
                result_count++;
                if (pending_matches.size() == 0)
                begin
                    $error("result with nothing expected: %h", m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    want = pending_matches.pop_front();
                    if (got.pattern !== want.pattern)
                    begin
                        $error("best_pattern expected %h actual %h", want.pattern, got.pattern);
                        error_count++;
                    end
                    if (got.index !== want.index)
                    begin
                        $error("best_index expected %0d actual %0d", want.index, got.index);
                        error_count++;
                    end
                    if (got.distance !== want.distance)
                    begin
                        $error("best_distance expected %0d actual %0d",
                               want.distance, got.distance);
                        error_count++;
                    end
                end
            end
        end
    end

    // stimulus
    initial
    begin
        logic [15:0] mask_set [4];
        match_t      first;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        error_count   = 0;
        result_count  = 0;
        item_count    = 0;
        send_idle_pct = 19;
        recv_idle_pct = 47;
        for (int j = 0; j < 4; j++)
            seed_care[j] = 16'hFFFF;
        rebuild_table();
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows: all-ones signature matches the full pattern at distance 0
        first = nearest_pattern('1);
        add_row(64'hFFFF_FFFF_FFFF_FFFF, first.distance == 0, 14'd0);
        add_row(64'h0, 1'b0, 14'd0);
        add_row(64'h0000_0000_0000_0001, 1'b0, 14'd0);
        add_row(64'h8000_0000_0000_0000, 1'b0, 14'd0);
        add_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 14'd0);
        add_row(64'h5555_5555_5555_5555, 1'b0, 14'd0);
        add_row(64'hFFFF_FFFF_0000_0000, 1'b0, 14'd0);
        add_row(64'h0000_0000_FFFF_FFFF, 1'b0, 14'd0);
        for (int i = 0; i < 8; i++)
            add_row(pattern_sig[i * 17 % NUM_ENTRIES], 1'b1, 14'd0);
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].has_dist && nearest_pattern(directed_rows[r].sig).distance
                != directed_rows[r].exp_dist)
            begin
                $error("table row %0d: distance expected %0d", r, directed_rows[r].exp_dist);
                error_count++;
            end
            send_signature(directed_rows[r].sig);
        end
        drain_results();

        // random phases over several mask settings, extremes first
        mask_set = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
        for (int phase = 0; phase < 12; phase++)
        begin
            if (phase == 4)
            begin
                send_idle_pct = 47;
                recv_idle_pct = 19;
            end
            if (phase == 8)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int j = 0; j < 4; j++)
            begin
                case (phase)
                    0:       mask_set[j] = 16'h0000;
                    1:       mask_set[j] = 16'hFFFF;
                    2:       mask_set[j] = 16'h8001 << j;
                    default: mask_set[j] = $urandom;
                endcase
                write_mask(j, mask_set[j]);
            end
            for (int n = 0; n < 128; n++)
            begin
                send_signature(random_signature());
                // hold off until the pipeline is empty
                if (n == 64)
                begin
                    s_axis_tvalid <= 1'b0;
                    while (pending_matches.size() != 0)
                        @(posedge clk);
                end
            end
            drain_results();
        end

        $display("ran %0d signatures over 13 mask settings, %0d results checked",
                 item_count, result_count);
        $display("mask extremes, sparse/dense/near-table signatures and idling on both sides");
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // overall time limit
    initial
    begin
        #60000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
